// ===== hdl/ffha_pkg.sv =====
// ffha_pkg: shared types and codes for the first-fit heap allocator
// no dependencies
`timescale 1ns / 1ps
package ffha_pkg;
  typedef struct packed {
    logic        op;
    logic [31:0] req_size;
    logic [31:0] free_addr;
    logic [31:0] stored_header;
  } ffha_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] user_addr;
    logic [31:0] header_word;
  } ffha_out_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOO_BIG  = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_CANARY   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic       OP_ALLOC    = 1'b0;
  localparam logic [0:0] CFG_BASE    = 1'd0;
  localparam logic [0:0] CFG_SIZE    = 1'd1;
  localparam logic [31:0] CANARY_MASK = 32'h0000_00FF;
  localparam logic [32:0] SIZE_LIMIT  = 33'h0_0100_0000;
endpackage

// ===== hdl/ffha_ram.sv =====
// ffha_ram: generic single-port-write, one-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/first_fit_heap_allocator_unit.sv =====
// first-fit heap allocator: one request at a time, result given as a one-cycle strobe
// allocate walks the table to the first fit, then shrinks it or, on an exact fit,
// removes it by copying later entries down; free walks to the first entry at or past
// the block, then merges it with neighbours or shifts later entries up to insert it.
// reset (synchronous, rst_n low): heap registers 0, table empty, idle
// a config write rebuilds the table to at most one entry (count based)
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit #(
  parameter int MIN_BLOCK   = 8,
  parameter int MAX_EXTENTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ffha_pkg::ffha_in_t in_data,
  output logic               out_valid,
  output ffha_pkg::ffha_out_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import ffha_pkg::*;

  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [32:0] AMASK = 33'(MIN_BLOCK - 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_EXTENTS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ARD   = 4'd1;
  localparam logic [3:0] S_ACHK  = 4'd2;
  localparam logic [3:0] S_RMRD  = 4'd3;
  localparam logic [3:0] S_RMWR  = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FCHK  = 4'd6;
  localparam logic [3:0] S_FPRV  = 4'd7;
  localparam logic [3:0] S_FDEC  = 4'd8;
  localparam logic [3:0] S_SHRD  = 4'd9;
  localparam logic [3:0] S_SHWR  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_PWAIT = 4'd12;

  logic [3:0]    state_r, state_nxt;
  logic [31:0]   base_r, base_nxt, size_r, size_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [32:0]   blk_r, blk_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [31:0]   s_i_r, s_i_nxt, l_i_r, l_i_nxt;
  logic          hit_r, hit_nxt, mnext_r, mnext_nxt;
  logic [7:0]    cnry_r, cnry_nxt;
  ffha_out_t     res_r, res_nxt;
  logic          ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   ws, wl, rs, rl;

  ffha_ram #(.WIDTH(32), .DEPTH(MAX_EXTENTS)) u_start (
    .clk(clk), .we(we), .waddr(waddr), .wdata(ws), .raddr(raddr), .rdata(rs));
  ffha_ram #(.WIDTH(32), .DEPTH(MAX_EXTENTS)) u_len (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wl), .raddr(raddr), .rdata(rl));

  // rebuild helpers
  logic [31:0] new_base, new_size;
  logic [32:0] ab, pad, rlen, cap;
  always_comb begin
    new_base = (cfg_index == CFG_BASE) ? cfg_wdata : base_r;
    new_size = (cfg_index == CFG_SIZE) ? cfg_wdata : size_r;
    ab   = ({1'b0, new_base} + AMASK) & ~AMASK;
    pad  = ab - {1'b0, new_base};
    rlen = ({1'b0, new_size} > pad) ? {1'b0, new_size} - pad : 33'd0;
    cap  = ab[32] ? 33'd0 : 33'h1_0000_0000 - ab;
    if (rlen > cap) rlen = cap;
    rlen = rlen & ~AMASK;
  end

  logic [32:0] sum33, end33, nsum33;
  logic [33:0] sum34;
  logic [31:0] fblk;
  logic [32:0] fsize;
  logic [CW-1:0] idxm1;
  always_comb begin
    fblk   = addr_r;
    idxm1  = idx_r - CW'(1);
    sum33  = {1'b0, rs} + {1'b0, rl};
    end33  = {1'b0, fblk} + blk_r;
    nsum33 = blk_r + {1'b0, l_i_r};
    sum34  = {2'b0, rl} + {1'b0, blk_r} + (mnext_r ? {2'b0, l_i_r} : 34'd0);
    fsize  = {9'd0, in_data.stored_header[31:8]};
  end

  always_comb begin
    state_nxt = state_r;
    base_nxt = base_r; size_nxt = size_r; cnt_nxt = cnt_r;
    idx_nxt = idx_r; blk_nxt = blk_r; addr_nxt = addr_r;
    s_i_nxt = s_i_r; l_i_nxt = l_i_r; hit_nxt = hit_r; mnext_nxt = mnext_r;
    cnry_nxt = cnry_r; res_nxt = res_r; ov_nxt = 1'b0;
    we = 1'b0; waddr = idx_r[AW-1:0]; ws = 32'd0; wl = 32'd0;
    raddr = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          base_nxt = new_base; size_nxt = new_size;
          we = 1'b1; waddr = '0; ws = ab[31:0]; wl = rlen[31:0];
          cnt_nxt = (rlen != 33'd0) ? CW'(1) : CW'(0);
        end else if (start && !ov_r) begin
          idx_nxt = '0; cnry_nxt = in_data.stored_header[7:0];
          res_nxt = '0;
          if (in_data.op == OP_ALLOC) begin
            blk_nxt = ({1'b0, in_data.req_size} + 33'd4 + AMASK) & ~AMASK;
            state_nxt = S_ARD;
          end else begin
            addr_nxt = in_data.free_addr - 32'd4;
            blk_nxt = fsize;
            state_nxt = S_FRD;
          end
        end
      end
      S_ARD: begin
        if (blk_r >= SIZE_LIMIT) begin
          res_nxt.status = ST_TOO_BIG; state_nxt = S_DONE;
        end else if (idx_r >= cnt_r) begin
          res_nxt.status = ST_NO_FIT; state_nxt = S_DONE;
        end else begin
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if ({1'b0, rl} >= blk_r) begin
          res_nxt.status = ST_OK;
          res_nxt.user_addr = rs + 32'd4;
          res_nxt.header_word = (blk_r[31:0] << 8) | (rs & CANARY_MASK);
          if ({1'b0, rl} == blk_r) begin
            state_nxt = S_RMRD;
          end else begin
            we = 1'b1; ws = rs + blk_r[31:0]; wl = rl - blk_r[31:0];
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
          state_nxt = S_ARD;
        end
      end
      // remove entry idx: copy idx+1 down until count-1
      S_RMRD: begin
        if (idx_r + CW'(1) >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          raddr = AW'(idx_r + CW'(1));
          state_nxt = S_RMWR;
        end
      end
      S_RMWR: begin
        we = 1'b1; ws = rs; wl = rl;
        idx_nxt = idx_r + CW'(1);
        state_nxt = S_RMRD;
      end
      // free: find first index with start >= fblk
      S_FRD: begin
        if (cnry_r != fblk[7:0]) begin
          res_nxt.status = ST_CANARY; state_nxt = S_DONE;
        end else if (blk_r == 33'd0) begin
          state_nxt = S_DONE;
        end else begin
          if (blk_r > 33'h1_0000_0000 - {1'b0, fblk})
            blk_nxt = 33'h1_0000_0000 - {1'b0, fblk};
          if (idx_r >= cnt_r) begin
            hit_nxt = 1'b0;
            raddr = AW'(idxm1);
            state_nxt = (idx_r == '0) ? S_FDEC : S_PWAIT;
            mnext_nxt = 1'b0;
          end else begin
            state_nxt = S_FCHK;
          end
        end
      end
      S_FCHK: begin
        if (rs < fblk) begin
          idx_nxt = idx_r + CW'(1);
          state_nxt = S_FRD;
        end else begin
          s_i_nxt = rs; l_i_nxt = rl;
          mnext_nxt = (end33 == {1'b0, rs});
          raddr = AW'(idxm1);
          state_nxt = (idx_r == '0) ? S_FDEC : S_PWAIT;
        end
      end
      S_PWAIT: begin
        raddr = AW'(idxm1);
        hit_nxt = (sum33 == {1'b0, fblk});
        state_nxt = S_FPRV;
      end
      S_FPRV: begin
        // rs/rl still hold entry idx-1
        if (hit_r) begin
          we = 1'b1; waddr = AW'(idxm1); ws = rs;
          wl = sum34[33:32] != 2'd0 ? 32'hFFFF_FFFF : sum34[31:0];
          if (mnext_r) state_nxt = S_RMRD;
          else state_nxt = S_DONE;
        end else begin
          state_nxt = S_FDEC;
        end
      end
      S_FDEC: begin
        if (mnext_r) begin
          we = 1'b1; ws = fblk;
          wl = nsum33[32] ? 32'hFFFF_FFFF : nsum33[31:0];
          state_nxt = S_DONE;
        end else if (cnt_r >= CMAX) begin
          res_nxt.status = ST_FULL; state_nxt = S_DONE;
        end else begin
          // shift up from count down to idx
          addr_nxt = addr_r;
          s_i_nxt = {{(32-CW){1'b0}}, cnt_r};
          state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        if (s_i_r[CW-1:0] == idx_r) begin
          we = 1'b1; ws = fblk; wl = blk_r[31:0];
          cnt_nxt = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          raddr = AW'(s_i_r[CW-1:0] - CW'(1));
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        we = 1'b1; waddr = AW'(s_i_r[CW-1:0]); ws = rs; wl = rl;
        s_i_nxt = s_i_r - 32'd1;
        state_nxt = S_SHRD;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; base_r <= '0; size_r <= '0; cnt_r <= '0;
      ov_r <= 1'b0; hit_r <= 1'b0; mnext_r <= 1'b0; cnry_r <= '0;
    end else begin
      state_r <= state_nxt; base_r <= base_nxt; size_r <= size_nxt;
      cnt_r <= cnt_nxt; ov_r <= ov_nxt; hit_r <= hit_nxt;
      mnext_r <= mnext_nxt; cnry_r <= cnry_nxt;
    end
    idx_r <= idx_nxt; blk_r <= blk_nxt; addr_r <= addr_nxt;
    s_i_r <= s_i_nxt; l_i_r <= l_i_nxt; res_r <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_data  = res_r;
endmodule
